>>> rtl/hbfrd_pkg.sv
// ----------------------------------------------------------------------------
// hbfrd_pkg
// Shared constants and types for the home bus frame receiver and decoder.
// ----------------------------------------------------------------------------
package hbfrd_pkg;

   // frame bytes on the bus
   localparam logic [7:0] START_BYTE   = 8'hA8;
   localparam logic [7:0] END_BYTE     = 8'hA3;
   localparam logic [7:0] TYPE_COMMAND = 8'h12;
   localparam logic [7:0] TYPE_STATUS  = 8'h15;
   localparam logic [7:0] STATE_MARK   = 8'hB8;
   localparam logic [7:0] ACK_BYTE     = 8'hA5;

   // number of captured bytes between start and end
   localparam int FRAME_LEN = 5;

   // event kinds
   localparam logic [1:0] EV_NO_MATCH     = 2'd0;
   localparam logic [1:0] EV_COMMAND      = 2'd1;
   localparam logic [1:0] EV_STATUS_REQ   = 2'd2;
   localparam logic [1:0] EV_STATE_CHANGE = 2'd3;

   // configuration register indexes
   localparam logic CSR_OWN_ADDRESS = 1'b0;
   localparam logic CSR_WATCH_MODE  = 1'b1;

   // captured frame bytes 1 to 5, byte 1 at index 0
   typedef logic [FRAME_LEN-1:0][7:0] frame_bytes_type;

   // one result item, event_kind in the lowest bits
   typedef struct packed {
      logic       send_ack;
      logic [7:0] command_value;
      logic [3:0] sub_address;
      logic [1:0] event_kind;
   } result_type;

endpackage

>>> rtl/hbfrd_decode.sv
// ----------------------------------------------------------------------------
// hbfrd_decode
// Frame check and decode on the end byte: checksum, address match, event kind.
// ----------------------------------------------------------------------------
module hbfrd_decode (
   input  hbfrd_pkg::frame_bytes_type frame_bytes,
   input  logic [7:0]                 end_byte,
   input  logic [3:0]                 own_address,
   input  logic                       watch_mode,
   output hbfrd_pkg::result_type      result
);
   import hbfrd_pkg::*;

   logic [7:0] check;
   logic       frame_good;

   // checksum over bytes 1 to 4 against byte 5
   assign check      = frame_bytes[0] ^ frame_bytes[1] ^ frame_bytes[2] ^ frame_bytes[3];
   assign frame_good = (end_byte == END_BYTE) && (check == frame_bytes[4]);

   // event selection
   always_comb begin
      result = '0;
      if (frame_good) begin
         if (watch_mode) begin
            if (frame_bytes[0] == STATE_MARK && frame_bytes[1][7:4] == own_address) begin
               result.event_kind    = EV_STATE_CHANGE;
               result.sub_address   = frame_bytes[1][3:0];
               result.command_value = frame_bytes[3];
            end
         end else if (frame_bytes[0][7:4] == own_address) begin
            if (frame_bytes[2] == TYPE_COMMAND) begin
               result.event_kind    = EV_COMMAND;
               result.sub_address   = frame_bytes[0][3:0];
               result.command_value = frame_bytes[3];
               result.send_ack      = 1'b1;
            end else if (frame_bytes[2] == TYPE_STATUS) begin
               result.event_kind  = EV_STATUS_REQ;
               result.sub_address = frame_bytes[0][3:0];
            end
         end
      end
   end

endmodule

>>> rtl/home_bus_frame_receiver_decoder_core.sv
// A frame-end item's result item is registered and is offered in the cycle after acceptance.
// Throughput: one item per cycle; a byte that ends a frame waits only while the
// result register is full and not being taken.
// Reset: synchronous, active high; clears the frame position, result valid and
// the configuration registers. Captured frame bytes are not reset.
// ----------------------------------------------------------------------------
// home_bus_frame_receiver_decoder_core
// Hunts for a home bus frame in the received byte stream, captures it and
// reports one decoded result item per frame end.
// ----------------------------------------------------------------------------
module home_bus_frame_receiver_decoder_core (
   input  logic        clock,
   input  logic        reset,
   // configuration port
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [3:0]  csr_wdata,
   // received bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // decoded results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] event_kind, [5:2] sub_address,
                                    // [13:6] command_value, [14] send_ack
);
   import hbfrd_pkg::*;

   localparam logic [2:0] POS_HUNT  = 3'd0;
   localparam logic [2:0] POS_FIRST = 3'd1;
   localparam logic [2:0] POS_LAST  = 3'd5;
   localparam logic [2:0] POS_END   = 3'd6;

   logic [3:0]      own_address_ff, own_address_in;
   logic            watch_mode_ff, watch_mode_in;
   logic [2:0]      position_ff, position_in;
   frame_bytes_type frame_bytes_ff, frame_bytes_in;
   logic            out_valid_ff, out_valid_in;
   result_type      out_data_ff, out_data_in;
   result_type      decoded;
   logic            accept;
   logic            at_end;

   // configuration registers
   always_comb begin
      own_address_in = own_address_ff;
      watch_mode_in  = watch_mode_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_OWN_ADDRESS: own_address_in = csr_wdata;
            CSR_WATCH_MODE:  watch_mode_in  = csr_wdata[0];
            default:         own_address_in = own_address_ff;
         endcase
      end
   end

   // handshake: only an end byte needs room in the result register
   assign at_end     = (position_ff == POS_END);
   assign req_tready = !at_end || !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   hbfrd_decode u_decode (
      .frame_bytes (frame_bytes_ff),
      .end_byte    (req_tdata),
      .own_address (own_address_ff),
      .watch_mode  (watch_mode_ff),
      .result      (decoded)
   );

   // frame position and byte capture
   always_comb begin
      position_in    = position_ff;
      frame_bytes_in = frame_bytes_ff;
      if (accept) begin
         case (position_ff) inside
            [POS_FIRST:POS_LAST]: begin
               frame_bytes_in[position_ff - POS_FIRST] = req_tdata;
               position_in = position_ff + 3'd1;
            end
            POS_END: position_in = POS_HUNT;
            default: position_in = (req_tdata == START_BYTE) ? POS_FIRST : POS_HUNT;
         endcase
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      if (accept && at_end) begin
         out_valid_in = 1'b1;
         out_data_in  = decoded;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
         watch_mode_ff  <= 1'b0;
         position_ff    <= POS_HUNT;
         out_valid_ff   <= 1'b0;
      end else begin
         own_address_ff <= own_address_in;
         watch_mode_ff  <= watch_mode_in;
         position_ff    <= position_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      frame_bytes_ff <= frame_bytes_in;
      out_data_ff    <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

endmodule

>>> tb/tb_home_bus_frame_receiver_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_home_bus_frame_receiver_decoder_core
// Feeds received bus bytes into the frame decoder under several address and
// mode settings and with random gaps on both streams. A behavioural model of
// the frame hunt and decode predicts each result item, and every result item
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_home_bus_frame_receiver_decoder_core;
   import hbfrd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 165;
   localparam int NUM_PHASES  = 8;
   localparam int PRINT_LIMIT = 40;

   // frame position codes of the model
   localparam logic [2:0] POS_HUNT  = 3'd0;
   localparam logic [2:0] POS_FIRST = 3'd1;
   localparam logic [2:0] POS_LAST  = 3'd5;
   localparam logic [2:0] POS_END   = 3'd6;

   // content shapes for random frames
   typedef enum int {
      SHAPE_COMMAND,
      SHAPE_STATUS,
      SHAPE_STATE,
      SHAPE_RANDOM
   } frame_shape_type;

   // --------------------------------------------------------------------------
   // decoder model and store of predicted events
   // --------------------------------------------------------------------------
   class decoded_event_model;
      logic [3:0] own_address;
      logic       watch_mode;
      logic [2:0] position;
      logic [7:0] captured [FRAME_LEN];
      result_type predicted_events [$];
      int         mismatches;

      function new();
         own_address = '0;
         watch_mode  = 1'b0;
         position    = POS_HUNT;
         mismatches  = 0;
         foreach (captured[i]) captured[i] = '0;
      endfunction

      function void take_config(logic index, logic [3:0] value);
         if (index == CSR_OWN_ADDRESS) begin
            own_address = value;
         end else begin
            watch_mode = value[0];
         end
      endfunction

      // note one accepted byte, predicting a result item on a frame end
      function void take_byte(logic [7:0] rx);
         result_type ev;
         logic [7:0] check_sum;
         if (position inside {[POS_FIRST:POS_LAST]}) begin
            captured[position - 1] = rx;
            position = position + 3'd1;
         end else if (position != POS_END) begin
            position = (rx == START_BYTE) ? POS_FIRST : POS_HUNT;
         end else begin
            position = POS_HUNT;
            ev = '0;
            ev.event_kind = EV_NO_MATCH;
            check_sum = captured[0] ^ captured[1] ^ captured[2] ^ captured[3];
            if (rx == END_BYTE && check_sum == captured[4]) begin
               if (watch_mode) begin
                  if (captured[0] == STATE_MARK && captured[1][7:4] == own_address) begin
                     ev.event_kind    = EV_STATE_CHANGE;
                     ev.sub_address   = captured[1][3:0];
                     ev.command_value = captured[3];
                  end
               end else if (captured[0][7:4] == own_address) begin
                  if (captured[2] == TYPE_COMMAND) begin
                     ev.event_kind    = EV_COMMAND;
                     ev.sub_address   = captured[0][3:0];
                     ev.command_value = captured[3];
                     ev.send_ack      = 1'b1;
                  end else if (captured[2] == TYPE_STATUS) begin
                     ev.event_kind  = EV_STATUS_REQ;
                     ev.sub_address = captured[0][3:0];
                  end
               end
            end
            predicted_events.push_back(ev);
         end
      endfunction

      task report_mismatch(input string msg);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
      endtask

      // compare one result item with the oldest prediction
      task check_event(input logic [14:0] data);
         result_type got;
         result_type want;
         got = data;
         if (predicted_events.size() == 0) begin
            report_mismatch($sformatf("result item %h with no prediction waiting", data));
         end else begin
            want = predicted_events.pop_front();
            if (got.event_kind != want.event_kind)
               report_mismatch($sformatf("event_kind %0d, want %0d",
                                         got.event_kind, want.event_kind));
            if (got.sub_address != want.sub_address)
               report_mismatch($sformatf("sub_address %h, want %h",
                                         got.sub_address, want.sub_address));
            if (got.command_value != want.command_value)
               report_mismatch($sformatf("command_value %h, want %h",
                                         got.command_value, want.command_value));
            if (got.send_ack != want.send_ack)
               report_mismatch($sformatf("send_ack %0b, want %0b",
                                         got.send_ack, want.send_ack));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_addr;
   logic [3:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [1:0] event_kind, [5:2] sub_address,
                             // [13:6] command_value, [14] send_ack

   decoded_event_model event_model = new();
   int send_idle_pct;
   int recv_stall_pct;
   int bytes_sent;
   int cycle_count;

   home_bus_frame_receiver_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) event_model.check_event(rsp_tdata[14:0]);
   end

   // send one byte, with random gaps before it
   task automatic push_byte(input logic [7:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      event_model.take_byte(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   // start byte, four body bytes, check byte (optionally spoilt), end byte
   task automatic push_frame(input logic [7:0] b1, input logic [7:0] b2,
                             input logic [7:0] b3, input logic [7:0] b4,
                             input logic [7:0] check_flip, input logic [7:0] end_byte);
      push_byte(START_BYTE);
      push_byte(b1);
      push_byte(b2);
      push_byte(b3);
      push_byte(b4);
      push_byte(b1 ^ b2 ^ b3 ^ b4 ^ check_flip);
      push_byte(end_byte);
   endtask

   // mostly well-formed frames with random content
   task automatic push_random_frame();
      logic [7:0]      addr;
      logic [7:0]      flip;
      logic [7:0]      end_byte;
      frame_shape_type shape;
      addr = {($urandom_range(0, 99) < 80) ? event_model.own_address : 4'($urandom),
              4'($urandom)};
      flip = ($urandom_range(0, 99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
      end_byte = ($urandom_range(0, 99) < 88) ? END_BYTE : 8'($urandom);
      shape = frame_shape_type'($urandom_range(0, 3));
      case (shape)
         SHAPE_COMMAND: begin
            push_frame(addr, 8'($urandom), TYPE_COMMAND, 8'($urandom), flip, end_byte);
         end
         SHAPE_STATUS: begin
            push_frame(addr, 8'($urandom), TYPE_STATUS, 8'($urandom), flip, end_byte);
         end
         SHAPE_STATE: begin
            push_frame(STATE_MARK, addr, 8'($urandom), 8'($urandom), flip, end_byte);
         end
         default: begin
            push_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       flip, end_byte);
         end
      endcase
   endtask

   // wait until the decoder has drained
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (event_model.predicted_events.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // both registers, spare bits of the mode word random
   task automatic write_config(input logic [3:0] own, input logic watch);
      logic [3:0] watch_word;
      watch_word = {3'($urandom), watch};
      csr_we    = 1'b1;
      csr_addr  = CSR_OWN_ADDRESS;
      csr_wdata = own;
      @(posedge clock);
      event_model.take_config(CSR_OWN_ADDRESS, own);
      @(negedge clock);
      csr_addr  = CSR_WATCH_MODE;
      csr_wdata = watch_word;
      @(posedge clock);
      event_model.take_config(CSR_WATCH_MODE, watch_word);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // stimulus
   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_addr       = CSR_OWN_ADDRESS;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      bytes_sent     = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed: extremes while hunting, then the special frames
      write_config(4'h0, 1'b0);
      push_byte(8'h00);
      push_byte(8'hFF);
      // command, with a start byte captured as data
      push_frame(8'h0F, START_BYTE, TYPE_COMMAND, 8'hFF, 8'h00, END_BYTE);
      // bad end byte that looks like a start byte, then a status request
      push_frame(8'h05, 8'h00, TYPE_STATUS, 8'h00, 8'h00, START_BYTE);
      push_frame(8'h03, 8'h00, TYPE_STATUS, 8'h77, 8'h00, END_BYTE);
      // state change shape with a bad check byte
      push_frame(STATE_MARK, 8'h0C, 8'h00, 8'h5A, 8'h01, END_BYTE);
      wait_idle();
      // state change in watch mode
      write_config(4'h0, 1'b1);
      push_frame(STATE_MARK, 8'h0C, 8'h00, 8'h5A, 8'h00, END_BYTE);

      // random phases over settings and idling patterns
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: write_config(4'hF, 1'b0);
            1: write_config(4'h0, 1'b1);
            2: write_config(4'hF, 1'b1);
            3: write_config(4'h0, 1'b0);
            default: write_config(4'($urandom), 1'($urandom));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         while (bytes_sent < 37 + (phase + 1) * PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            push_random_frame();
         end
      end

      wait_idle();
      if (event_model.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/hbfrd_pkg.sv
rtl/hbfrd_decode.sv
rtl/home_bus_frame_receiver_decoder_core.sv
tb/tb_home_bus_frame_receiver_decoder_core.sv
